// ===== src/sh13_pkg.sv =====
package sh13_pkg;

  localparam int LANE_W       = 64;
  localparam int WORD_COUNT   = 6;
  localparam int FINAL_ROUNDS = 3;
  // two half-round cells per SipRound
  localparam int NUM_STAGES   = 2 * (WORD_COUNT + FINAL_ROUNDS);

  typedef logic [LANE_W-1:0] lane_word_t;

  typedef struct packed {
    lane_word_t a;
    lane_word_t b;
    lane_word_t c;
    lane_word_t d;
  } lanes_t;

  typedef logic [WORD_COUNT-1:0][LANE_W-1:0] words_t;

  localparam lane_word_t LANE_INIT0 = 64'h736f6d6570736575;
  localparam lane_word_t LANE_INIT1 = 64'h646f72616e646f6d;
  localparam lane_word_t LANE_INIT2 = 64'h6c7967656e657261;
  localparam lane_word_t LANE_INIT3 = 64'h7465646279746573;
  localparam lane_word_t FINAL_MARK = 64'h00000000000000ff;

  // rotate left by a constant amount
  function automatic lane_word_t rotl(input lane_word_t x, input int r);
    rotl = (x << r) | (x >> (LANE_W - r));
  endfunction

endpackage

// ===== src/sh13_cell.sv =====
module sh13_cell
  import sh13_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  lanes_t lanes_in,
  input  words_t words_in,
  output logic   out_valid,
  input  logic   out_ready,
  output lanes_t lanes_out,
  output words_t words_out
);

  localparam int ROUND  = STAGE / 2;
  localparam int HALF   = STAGE % 2;
  localparam bit ABSORB = (ROUND < WORD_COUNT);
  localparam bit MARK   = (ROUND == WORD_COUNT) && (HALF == 0);
  localparam int WIDX   = ABSORB ? ROUND : 0;

  logic   valid_r;
  lanes_t lanes_r;
  words_t words_r;
  lanes_t pre;
  lanes_t lanes_nxt;

  always_comb begin
    pre = lanes_in;
    if (ABSORB && HALF == 0) begin
      pre.d = pre.d ^ words_in[WIDX];
    end
    if (MARK) begin
      pre.c = pre.c ^ FINAL_MARK;
    end
    lanes_nxt = pre;
    if (HALF == 0) begin
      // a += b; b = rotl13 ^ a; a = rotl32; c += d; d = rotl16 ^ c
      lanes_nxt.a = rotl(pre.a + pre.b, 32);
      lanes_nxt.b = rotl(pre.b, 13) ^ (pre.a + pre.b);
      lanes_nxt.c = pre.c + pre.d;
      lanes_nxt.d = rotl(pre.d, 16) ^ (pre.c + pre.d);
    end else begin
      // a += d; d = rotl21 ^ a; c += b; b = rotl17 ^ c; c = rotl32
      lanes_nxt.a = pre.a + pre.d;
      lanes_nxt.d = rotl(pre.d, 21) ^ (pre.a + pre.d);
      lanes_nxt.c = rotl(pre.c + pre.b, 32);
      lanes_nxt.b = rotl(pre.b, 17) ^ (pre.c + pre.b);
      if (ABSORB) begin
        lanes_nxt.a = lanes_nxt.a ^ words_in[WIDX];
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      lanes_r <= lanes_nxt;
      words_r <= words_in;
    end
  end

  assign out_valid = valid_r;
  assign lanes_out = lanes_r;
  assign words_out = words_r;

endmodule

// ===== src/siphash13_256_extra_core.sv =====
// Keyless SipHash-1-3 over four value words and two extra words.
// An accepted input beat reaches out_tvalid through nine rounds, each split
// over two half-round cells of one 64-bit add level each.
// Throughput: one beat per cycle, set by the cell chain; each cell stalls
// only when it holds a beat its successor cannot take.
// Reset (rst_n low, synchronous) empties the chain; lane data is not cleared.
module siphash13_256_extra_core
  import sh13_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // fields from bit 0 up: word_zero, word_one, word_two, word_three,
  // extra_first, extra_second (64 bits each)
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // fields from bit 0 up: hash_out (64 bits)
  output logic [63:0]  out_tdata
);

  // chain links: index i is the input side of cell i, NUM_STAGES the tail
  logic   valid_l [NUM_STAGES+1];
  logic   ready_l [NUM_STAGES+1];
  lanes_t lanes_l [NUM_STAGES+1];
  words_t words_l [NUM_STAGES];

  // head of the chain: lanes start from the SipHash constants (zero key)
  assign valid_l[0]   = in_tvalid;
  assign in_tready    = ready_l[0];
  assign lanes_l[0].a = LANE_INIT0;
  assign lanes_l[0].b = LANE_INIT1;
  assign lanes_l[0].c = LANE_INIT2;
  assign lanes_l[0].d = LANE_INIT3;
  assign words_l[0]   = in_tdata;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
    if (i < NUM_STAGES - 1) begin : g_mid
      sh13_cell #(.STAGE(i)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_l[i]),
        .in_ready  (ready_l[i]),
        .lanes_in  (lanes_l[i]),
        .words_in  (words_l[i]),
        .out_valid (valid_l[i+1]),
        .out_ready (ready_l[i+1]),
        .lanes_out (lanes_l[i+1]),
        .words_out (words_l[i+1])
      );
    end else begin : g_last
      // the words are fully absorbed long before the tail
      sh13_cell #(.STAGE(i)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_l[i]),
        .in_ready  (ready_l[i]),
        .lanes_in  (lanes_l[i]),
        .words_in  (words_l[i]),
        .out_valid (valid_l[i+1]),
        .out_ready (ready_l[i+1]),
        .lanes_out (lanes_l[i+1]),
        .words_out ()
      );
    end
  end

  // tail: the last cell's register is the output register
  assign ready_l[NUM_STAGES] = out_tready;
  assign out_tvalid = valid_l[NUM_STAGES];
  assign out_tdata  = lanes_l[NUM_STAGES].a ^ lanes_l[NUM_STAGES].b
                    ^ lanes_l[NUM_STAGES].c ^ lanes_l[NUM_STAGES].d;

endmodule
